/* rtl/snwr_pkg.sv */
// ----------------------------------------------------------------------------
// snwr_pkg: shared types and codes for the stop-and-wait receiver
// Packet kinds, result kinds, channel payload structs and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package snwr_pkg;

    // incoming packet kinds
    localparam logic [2:0] PK_DATA      = 3'd0;
    localparam logic [2:0] PK_LAST_DATA = 3'd1;
    localparam logic [2:0] PK_ACK       = 3'd2;
    localparam logic [2:0] PK_NACK      = 3'd3;
    localparam logic [2:0] PK_TERMINATE = 3'd4;
    localparam logic [2:0] PK_OTHER     = 3'd5;
    localparam logic [2:0] PK_LINK_LOST = 3'd6;

    // result kinds
    localparam logic [2:0] RK_SEND_ACK  = 3'd0;
    localparam logic [2:0] RK_SEND_NACK = 3'd1;
    localparam logic [2:0] RK_MSG_BYTE  = 3'd2;
    localparam logic [2:0] RK_ACK_SEEN  = 3'd3;
    localparam logic [2:0] RK_NACK_SEEN = 3'd4;
    localparam logic [2:0] RK_LINK_DOWN = 3'd5;

    typedef struct packed {
        logic [2:0]         pkt_kind;
        logic signed [31:0] stated_sum;
        logic [7:0]         data_byte;
        logic               has_byte;
        logic               byte_last;
    } snwr_in_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic       message_done;
        logic       run_last;
    } snwr_out_t;

    // controller -> datapath
    typedef struct packed {
        logic       stage;       // take byte/sum of the accepted item
        logic       latch;       // capture kind and stated sum of final item
        logic       clear;       // drop staged packet
        logic       drain_start; // point read index at entry zero
        logic       drain_step;  // advance read index
        logic       emit;        // load output register
        logic [2:0] emit_kind;
        logic       emit_byte;   // take payload from buffer read data
        logic       emit_done;
        logic       emit_last;
    } snwr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;        // kind of the packet-ending item
        logic       ok;          // sum matches and no overflow
        logic       cnt_zero;
        logic       drain_end;   // current read entry is the last staged one
        logic       slot_free;   // output register can take a result
    } snwr_sts_t;

endpackage

/* rtl/stop_and_wait_receiver_unit.sv */
// Flow: a non-final packet item is taken every cycle while the unit is idle.
// A final item is followed by a decision state, after which the results are
// registered one per cycle while res is not stalled (staged bytes, then ACK
// and, for a last-data packet, a message-done ACK). Reset: link alive, empty
// staging, no result pending; buffer contents are not cleared (only entries
// below the count are read).
// ----------------------------------------------------------------------------
// stop_and_wait_receiver_unit: receive side of a stop-and-wait ARQ link
// Verifies packet checksums, forwards verified bytes and generates ACK/NACK.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver_unit #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_stall,
    input  snwr_pkg::snwr_in_t  pkt,
    output logic                res_valid,
    input  logic                res_stall,
    output snwr_pkg::snwr_out_t res
);

    snwr_pkg::snwr_cmd_t cmd;
    snwr_pkg::snwr_sts_t sts;

    snwr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_kind  (pkt.pkt_kind),
        .pkt_last  (pkt.byte_last),
        .pkt_stall (pkt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    snwr_dp #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .cmd       (cmd),
        .sts       (sts),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

/* rtl/snwr_dp.sv */
// ----------------------------------------------------------------------------
// snwr_dp: receiver datapath
// Staging buffer, byte count, overflow flag, running sum, drain index
// and the output register.
// ----------------------------------------------------------------------------
module snwr_dp #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  snwr_pkg::snwr_in_t  pkt,
    input  snwr_pkg::snwr_cmd_t cmd,
    output snwr_pkg::snwr_sts_t sts,
    input  logic                res_stall,
    output logic                res_valid,
    output snwr_pkg::snwr_out_t res
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW = $clog2(PAYLOAD_MAX + 1);

    logic [7:0]          mem [PAYLOAD_MAX];
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         sum_reg, sum_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [2:0]          kind_reg;
    logic [31:0]         stated_reg;
    logic [7:0]          rd_data_reg;
    logic                res_valid_reg, res_valid_next;
    snwr_pkg::snwr_out_t res_reg;

    logic                cnt_full;
    logic                mem_we;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       idx_inc;

    assign cnt_full = (cnt_reg == CW'(PAYLOAD_MAX));
    assign mem_we   = cmd.stage && pkt.has_byte && !cnt_full;
    assign idx_inc  = idx_reg + CW'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        sum_next = sum_reg;
        if (cmd.clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
            sum_next = '0;
        end
        else if (cmd.stage && pkt.has_byte)
        begin
            if (cnt_full)
                ovf_next = 1'b1;
            else
                cnt_next = cnt_reg + CW'(1);
            sum_next = sum_reg + {{24{pkt.data_byte[7]}}, pkt.data_byte};
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.drain_start)
            idx_next = '0;
        else if (cmd.drain_step)
            idx_next = idx_inc;
    end

    // read one entry ahead so the data lines up with idx_reg
    assign rd_addr = (idx_next < CW'(PAYLOAD_MAX)) ? idx_next[AW-1:0] : '0;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.emit)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cnt_reg[AW-1:0]] <= pkt.data_byte;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg   <= pkt.pkt_kind;
            stated_reg <= pkt.stated_sum;
        end
        if (cmd.emit)
        begin
            res_reg.out_kind     <= cmd.emit_kind;
            res_reg.out_byte     <= cmd.emit_byte ? rd_data_reg : 8'd0;
            res_reg.message_done <= cmd.emit_done;
            res_reg.run_last     <= cmd.emit_last;
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.ok        = !ovf_reg && (sum_reg == stated_reg);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.drain_end = (idx_inc == cnt_reg);
    assign sts.slot_free = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/snwr_ctrl.sv */
// ----------------------------------------------------------------------------
// snwr_ctrl: receiver controller
// Takes packet items, decides at packet end and sequences the results.
// ----------------------------------------------------------------------------
module snwr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    input  logic [2:0]          pkt_kind,
    input  logic                pkt_last,
    output logic                pkt_stall,
    input  snwr_pkg::snwr_sts_t sts,
    output snwr_pkg::snwr_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ACK   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;
    localparam logic [2:0] S_DEAD  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] resp_reg, resp_next;

    assign pkt_stall = !((state_reg == S_IDLE) || (state_reg == S_DEAD));

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    if ((pkt_kind == snwr_pkg::PK_TERMINATE) ||
                        (pkt_kind == snwr_pkg::PK_LINK_LOST))
                    begin
                        cmd.clear  = 1'b1;
                        resp_next  = snwr_pkg::RK_LINK_DOWN;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.stage = 1'b1;
                        if (pkt_last)
                        begin
                            cmd.latch  = 1'b1;
                            state_next = S_EVAL;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                priority if ((sts.kind == snwr_pkg::PK_DATA) ||
                             (sts.kind == snwr_pkg::PK_LAST_DATA))
                begin
                    if (!sts.ok)
                    begin
                        resp_next  = snwr_pkg::RK_SEND_NACK;
                        state_next = S_RESP;
                    end
                    else if (sts.cnt_zero)
                        state_next = S_ACK;
                    else
                    begin
                        cmd.drain_start = 1'b1;
                        state_next      = S_DRAIN;
                    end
                end
                else if (sts.kind == snwr_pkg::PK_ACK)
                begin
                    resp_next  = snwr_pkg::RK_ACK_SEEN;
                    state_next = S_RESP;
                end
                else if (sts.kind == snwr_pkg::PK_NACK)
                begin
                    resp_next  = snwr_pkg::RK_NACK_SEEN;
                    state_next = S_RESP;
                end
                else
                begin
                    // other kinds end the packet silently
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = snwr_pkg::RK_MSG_BYTE;
                    cmd.emit_byte  = 1'b1;
                    cmd.drain_step = 1'b1;
                    if (sts.drain_end)
                        state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = snwr_pkg::RK_SEND_ACK;
                    if (sts.kind == snwr_pkg::PK_LAST_DATA)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.emit_last = 1'b1;
                        cmd.clear     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = snwr_pkg::RK_SEND_ACK;
                    cmd.emit_done = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = resp_reg;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    if (resp_reg == snwr_pkg::RK_LINK_DOWN)
                        state_next = S_DEAD;
                    else
                        state_next = S_IDLE;
                end
            end
            S_DEAD:
            begin
                // link is gone: swallow everything until reset
                state_next = S_DEAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= snwr_pkg::RK_SEND_NACK;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

/* rtl/snwr_chk.sv */
// ----------------------------------------------------------------------------
// snwr_chk: port-level checks for the stop-and-wait receiver
// Watches the top-level channels and flags sequencing errors.
// ----------------------------------------------------------------------------
module snwr_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                pkt_valid,
    input logic                pkt_stall,
    input snwr_pkg::snwr_in_t  pkt,
    input logic                res_valid,
    input logic                res_stall,
    input snwr_pkg::snwr_out_t res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // after link-down transfer: nothing more, input is swallowed
    a_link_down: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && (res.out_kind == snwr_pkg::RK_LINK_DOWN)
        |=> !res_valid && !pkt_stall)
        else $error("activity after link down");

    // mid-packet items never hold up the next one
    a_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_stall && !pkt.byte_last &&
        (pkt.pkt_kind != snwr_pkg::PK_TERMINATE) &&
        (pkt.pkt_kind != snwr_pkg::PK_LINK_LOST)
        |=> !pkt_stall)
        else $error("stall after mid-packet item");

    // a result run has no gaps once its results are taken
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res.run_last |=> res_valid)
        else $error("gap inside result run");

endmodule

bind stop_and_wait_receiver_unit snwr_chk u_snwr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
